>>> sv/met_pkg.sv
// Shared types, constants and helpers for the escape-time unit.
// Used by met_mul and mandelbrot_escape_time_unit; depends on nothing.
package met_pkg;

   // Fixed-point format of c and z: signed Q4.FRAC_BITS. It equals the
   // register format, so a mapped point needs no format conversion.
   localparam int FRAC_BITS = 28;
   localparam int INT_BITS  = 4;
   localparam int Z_W       = INT_BITS + FRAC_BITS;
   localparam int PROD_W    = 2 * Z_W;
   localparam int WIDE_W    = PROD_W + 2;

   localparam int COORD_W   = 10;
   localparam int STEP_W    = 31;
   localparam int LIMIT_W   = 16;
   localparam int SHADE_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // |z|^2 is compared against 4.0 at the full product scale.
   localparam logic [PROD_W:0] ESCAPE_BOUND = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

   localparam logic signed [Z_W-1:0]  REAL_ORIGIN_RST = -32'sd536870912;
   localparam logic signed [Z_W-1:0]  IMAG_ORIGIN_RST = -32'sd402653184;
   localparam logic [STEP_W-1:0]      REAL_STEP_RST   = STEP_W'(786432);
   localparam logic [STEP_W-1:0]      IMAG_STEP_RST   = STEP_W'(786432);
   localparam logic [LIMIT_W-1:0]     LIMIT_RST       = LIMIT_W'(1000);

   localparam logic [SHADE_W-1:0] SHADE_IN_SET = 2'd0;
   localparam logic [SHADE_W-1:0] SHADE_MEDIUM = 2'd1;
   localparam logic [SHADE_W-1:0] SHADE_DARK   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REAL_ORIGIN = 3'd0,
      CSR_IMAG_ORIGIN = 3'd1,
      CSR_REAL_STEP   = 3'd2,
      CSR_IMAG_STEP   = 3'd3,
      CSR_ITER_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] iteration_count;
      logic [SHADE_W-1:0] shade;
   } rsp_payload_type;

   // Clamp a wide signed value into the Q4.F range.
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-Z_W:0] top;
      logic signed [Z_W-1:0] res;
      top = v[WIDE_W-1:Z_W-1];
      if ((&top) || !(|top)) begin
         res = v[Z_W-1:0];
      end else if (v[WIDE_W-1]) begin
         res = {1'b1, {(Z_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(Z_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

>>> sv/met_mul.sv
// Shared signed multiplier with a registered product.
// Depends on met_pkg for operand and product widths.
module met_mul (
   input  logic                          clock,
   input  logic signed [met_pkg::Z_W-1:0]    op_a,
   input  logic signed [met_pkg::Z_W-1:0]    op_b,
   output logic signed [met_pkg::PROD_W-1:0] prod_ff
);
   import met_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> sv/mandelbrot_escape_time_unit.sv
// Mandelbrot escape-time unit: maps a pixel to c and iterates z = z*z + c on
// one shared 32x32 multiplier. The pixel is mapped to c in ST_MAP_R, ST_MAP_I
// and ST_MAP_C; each iteration passes through ST_SQ_R, ST_SQ_I and ST_TEST (the
// multiplier passes for zr*zr, zi*zi and zr*zi), then ST_UPDATE. The escape test
// that ends a pixel stops after ST_TEST, and ST_DONE loads the result register.
// A pixel that reaches the limit skips that last test, and a zero limit skips
// the iteration altogether. A result that is not taken holds the next pixel in
// ST_DONE.
// The unit takes one pixel at a time; the next request beat is accepted as
// soon as the previous result sits in the output register, even if it has not
// been taken yet. Configuration writes are always accepted and take effect at
// once; they are meant to happen only while the unit is idle. Depends on
// met_pkg and met_mul.
module mandelbrot_escape_time_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  met_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output met_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [met_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0] csr_data
);
   import met_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MAP_R  = 9'b000000010,
      ST_MAP_I  = 9'b000000100,
      ST_MAP_C  = 9'b000001000,
      ST_SQ_R   = 9'b000010000,
      ST_SQ_I   = 9'b000100000,
      ST_TEST   = 9'b001000000,
      ST_UPDATE = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [Z_W-1:0]   real_origin_ff, imag_origin_ff;
   logic [STEP_W-1:0]       real_step_ff, imag_step_ff;
   logic [LIMIT_W-1:0]      iter_limit_ff;

   logic [COORD_W-1:0]      pixel_x_ff, pixel_x_in;
   logic [COORD_W-1:0]      pixel_y_ff, pixel_y_in;
   logic signed [Z_W-1:0]   cr_ff, cr_in, ci_ff, ci_in;
   logic signed [Z_W-1:0]   zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PROD_W-1:0] rr_ff, rr_in;
   logic signed [PROD_W:0]  diff_ff, diff_in;
   logic [LIMIT_W-1:0]      iter_cnt_ff, iter_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   logic signed [Z_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [WIDE_W-1:0] map_sum;
   logic [PROD_W:0]          mag_sq;
   logic                     escaped;
   logic signed [WIDE_W-1:0] zr_sum, zi_sum;
   logic [LIMIT_W-1:0]       iter_next;
   logic                     rsp_free;

   met_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         real_origin_ff <= REAL_ORIGIN_RST;
         imag_origin_ff <= IMAG_ORIGIN_RST;
         real_step_ff   <= REAL_STEP_RST;
         imag_step_ff   <= IMAG_STEP_RST;
         iter_limit_ff  <= LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REAL_ORIGIN: real_origin_ff <= csr_data[Z_W-1:0];
            CSR_IMAG_ORIGIN: imag_origin_ff <= csr_data[Z_W-1:0];
            CSR_REAL_STEP:   real_step_ff   <= csr_data[STEP_W-1:0];
            CSR_IMAG_STEP:   imag_step_ff   <= csr_data[STEP_W-1:0];
            CSR_ITER_LIMIT:  iter_limit_ff  <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_MAP_R: begin
            mul_a = Z_W'(pixel_x_ff);
            mul_b = Z_W'(real_step_ff);
         end
         ST_MAP_I: begin
            mul_a = Z_W'(pixel_y_ff);
            mul_b = Z_W'(imag_step_ff);
         end
         ST_SQ_R: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_SQ_I: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // The product is non-negative here, so the origin is the only signed term.
   assign map_sum = WIDE_W'(state_ff == ST_MAP_I ? real_origin_ff : imag_origin_ff)
                    + WIDE_W'(prod_ff);

   // Both squares are non-negative, so the sum fits one extra bit unsigned.
   assign mag_sq  = (PROD_W + 1)'(unsigned'(rr_ff)) + (PROD_W + 1)'(unsigned'(prod_ff));
   assign escaped = (mag_sq >= ESCAPE_BOUND);

   // Arithmetic right shifts round toward minus infinity, as required.
   assign zr_sum = WIDE_W'(diff_ff >>> FRAC_BITS) + WIDE_W'(cr_ff);
   assign zi_sum = (WIDE_W'(prod_ff) <<< 1) >>> FRAC_BITS;

   assign iter_next = iter_cnt_ff + LIMIT_W'(1);

   always_comb begin
      state_in       = state_ff;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      rr_in          = rr_ff;
      diff_in        = diff_ff;
      iter_cnt_in    = iter_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pixel_x_in  = req_payload.pixel_x;
               pixel_y_in  = req_payload.pixel_y;
               zr_in       = '0;
               zi_in       = '0;
               iter_cnt_in = '0;
               state_in    = ST_MAP_R;
            end
         end
         ST_MAP_R: begin
            state_in = ST_MAP_I;
         end
         ST_MAP_I: begin
            cr_in    = sat_z(map_sum);
            state_in = ST_MAP_C;
         end
         ST_MAP_C: begin
            ci_in    = sat_z(map_sum);
            state_in = (iter_limit_ff == '0) ? ST_DONE : ST_SQ_R;
         end
         ST_SQ_R: begin
            state_in = ST_SQ_I;
         end
         ST_SQ_I: begin
            rr_in    = prod_ff;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            diff_in  = (PROD_W + 1)'(rr_ff) - (PROD_W + 1)'(prod_ff);
            state_in = escaped ? ST_DONE : ST_UPDATE;
         end
         ST_UPDATE: begin
            zr_in       = sat_z(zr_sum);
            zi_in       = sat_z(zi_sum + WIDE_W'(ci_ff));
            iter_cnt_in = iter_next;
            state_in    = (iter_next < iter_limit_ff) ? ST_SQ_R : ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.iteration_count = iter_cnt_ff;
               if (iter_cnt_ff == iter_limit_ff) begin
                  rsp_payload_in.shade = SHADE_IN_SET;
               end else if (iter_cnt_ff < (iter_limit_ff >> 1)) begin
                  rsp_payload_in.shade = SHADE_MEDIUM;
               end else begin
                  rsp_payload_in.shade = SHADE_DARK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_cnt_ff  <= iter_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      cr_ff          <= cr_in;
      ci_ff          <= ci_in;
      zr_ff          <= zr_in;
      zi_ff          <= zi_in;
      rr_ff          <= rr_in;
      diff_ff        <= diff_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // A request beat always starts the mapping of the pixel.
   a_req_starts_map: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MAP_R))
      else $error("request beat did not start the pixel mapping");

   // The iteration count never passes the limit while a pixel is in flight.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_MAP_R) |-> (iter_cnt_ff <= iter_limit_ff))
      else $error("iteration count exceeded the limit");

   // A result beat is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result loaded over a pending result");

   // An in-set shade always carries a count equal to the limit.
   a_in_set_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.shade == SHADE_IN_SET)
         |-> (rsp_payload_ff.iteration_count == iter_limit_ff))
      else $error("in-set shade with a count below the limit");

endmodule

>>> tb/tb_mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time_unit. It sends pixels under a range of
// register settings and checks every result against an escape-time predictor.
// Depends on met_pkg and the RTL of the unit.
module tb_mandelbrot_escape_time_unit;
   import met_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 10_000_000;
   localparam int unsigned RANDOM_PHASES    = 12;
   localparam int unsigned PIXELS_PER_PHASE = 50;
   localparam int unsigned SETTLE_CYCLES    = 20;
   localparam int unsigned REPORT_LINES     = 50;
   localparam int          CSR_FIRST_UNUSED = 5;
   localparam int          CSR_LAST_INDEX   = (1 << CSR_IDX_W) - 1;
   localparam logic signed [69:0] Q_MAX     = 70'sd2147483647;
   localparam logic signed [69:0] Q_MIN     = -70'sd2147483648;
   localparam logic signed [69:0] RADIUS_SQ = 70'sd1 <<< (2 * FRAC_BITS + 2);

   typedef struct packed {
      req_payload_type pixel;
      rsp_payload_type result;
   } escape_expect_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Copy of the register file as the unit should see it.
   logic signed [Z_W-1:0]  real_origin_q;
   logic signed [Z_W-1:0]  imag_origin_q;
   logic [STEP_W-1:0]      real_step_q;
   logic [STEP_W-1:0]      imag_step_q;
   logic [LIMIT_W-1:0]     limit_q;

   req_payload_type        pending_pixels[$];
   escape_expect_type      expected_escapes[$];
   int unsigned            req_idle = 0;
   int unsigned            rsp_idle = 0;
   int unsigned            error_count = 0;
   int unsigned            cycle_count = 0;
   bit                     calm_sides = 1'b0;

   mandelbrot_escape_time_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [69:0] clamp_q4(input logic signed [69:0] v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic logic signed [69:0] map_coord(input logic signed [Z_W-1:0] origin,
         input logic [STEP_W-1:0] stride, input logic [COORD_W-1:0] idx);
      logic signed [69:0] o, s, k;
      o = origin;
      s = stride;
      k = idx;
      return clamp_q4(o + k * s);
   endfunction

   function automatic rsp_payload_type predict_escape(input req_payload_type px);
      logic signed [69:0] cr, ci, zr, zi, rr, ii, ri;
      int unsigned n, lim;
      bit escaped;
      rsp_payload_type res;
      cr = map_coord(real_origin_q, real_step_q, px.pixel_x);
      ci = map_coord(imag_origin_q, imag_step_q, px.pixel_y);
      zr = '0;
      zi = '0;
      n = 0;
      lim = limit_q;
      escaped = 1'b0;
      while (n < lim && !escaped) begin
         rr = zr * zr;
         ii = zi * zi;
         if (rr + ii >= RADIUS_SQ) begin
            escaped = 1'b1;
         end else begin
            ri = zr * zi;
            zr = clamp_q4(((rr - ii) >>> FRAC_BITS) + cr);
            zi = clamp_q4(((ri + ri) >>> FRAC_BITS) + ci);
            n++;
         end
      end
      res.iteration_count = n[LIMIT_W-1:0];
      if (n == lim) begin
         res.shade = SHADE_IN_SET;
      end else if (n < lim / 2) begin
         res.shade = SHADE_MEDIUM;
      end else begin
         res.shade = SHADE_DARK;
      end
      return res;
   endfunction

   function automatic int unsigned draw_idle();
      return calm_sides ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < REPORT_LINES) $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         real_origin_q <= REAL_ORIGIN_RST;
         imag_origin_q <= IMAG_ORIGIN_RST;
         real_step_q   <= REAL_STEP_RST;
         imag_step_q   <= IMAG_STEP_RST;
         limit_q       <= LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REAL_ORIGIN: real_origin_q <= csr_data;
            CSR_IMAG_ORIGIN: imag_origin_q <= csr_data;
            CSR_REAL_STEP:   real_step_q   <= csr_data[STEP_W-1:0];
            CSR_IMAG_STEP:   imag_step_q   <= csr_data[STEP_W-1:0];
            CSR_ITER_LIMIT:  limit_q       <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // The expectation is formed when the request beat is taken, so it sees the
   // settings that were live for that pixel.
   always @(posedge clock) begin : pixel_driver
      escape_expect_type entry;
      if (reset) begin
         req_valid <= 1'b0;
         req_idle  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            entry.pixel  = req_payload;
            entry.result = predict_escape(req_payload);
            expected_escapes.push_back(entry);
         end
         if (!req_valid || req_ready) begin
            if (req_idle != 0) begin
               req_idle  <= req_idle - 1;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_payload <= pending_pixels.pop_front();
               req_valid   <= 1'b1;
               req_idle    <= draw_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      escape_expect_type entry;
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_idle  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_escapes.size() == 0) begin
            report_mismatch($sformatf("result count %0d shade %0d with no pixel pending",
                                      rsp_payload.iteration_count, rsp_payload.shade));
         end else begin
            entry = expected_escapes.pop_front();
            if (rsp_payload.iteration_count !== entry.result.iteration_count)
               report_mismatch($sformatf("pixel (%0d,%0d) count %0d, predicted %0d",
                                         entry.pixel.pixel_x, entry.pixel.pixel_y,
                                         rsp_payload.iteration_count,
                                         entry.result.iteration_count));
            if (rsp_payload.shade !== entry.result.shade)
               report_mismatch($sformatf("pixel (%0d,%0d) shade %0d, predicted %0d",
                                         entry.pixel.pixel_x, entry.pixel.pixel_y,
                                         rsp_payload.shade, entry.result.shade));
         end
         hold = draw_idle();
         rsp_idle  <= hold;
         rsp_ready <= (hold == 0);
      end else if (rsp_idle != 0) begin
         rsp_idle  <= rsp_idle - 1;
         rsp_ready <= (rsp_idle == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_pixel(input int unsigned x, input int unsigned y);
      req_payload_type px;
      px.pixel_x = COORD_W'(x);
      px.pixel_y = COORD_W'(y);
      pending_pixels.push_back(px);
   endtask

   // Polls at the falling edge so the queues and valid have settled, then
   // returns on a rising edge ready to drive again.
   task automatic drain_escapes();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_escapes.size() != 0);
      @(posedge clock);
   endtask

   // Valid is left high so back-to-back writes need no second assignment.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
   endtask

   task automatic apply_setting(input logic signed [Z_W-1:0] re_org, im_org,
         input logic [STEP_W-1:0] re_stride, im_stride, input logic [LIMIT_W-1:0] lim);
      csr_write(CSR_REAL_ORIGIN, re_org);
      csr_write(CSR_IMAG_ORIGIN, im_org);
      csr_write(CSR_REAL_STEP, CSR_DATA_W'(re_stride));
      csr_write(CSR_IMAG_STEP, CSR_DATA_W'(im_stride));
      csr_write(CSR_ITER_LIMIT, CSR_DATA_W'(lim));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [Z_W-1:0] pick_origin(input int base, input int unsigned span);
      if ($urandom_range(0, 9) < 3) return $urandom;
      return base + int'($urandom_range(0, span));
   endfunction

   function automatic logic [STEP_W-1:0] pick_stride();
      if ($urandom_range(0, 9) < 3) return STEP_W'($urandom);
      return STEP_W'($urandom_range(0, 1 << 20));
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      if ($urandom_range(0, 3) == 0) return LIMIT_W'($urandom_range(49, 300));
      return LIMIT_W'($urandom_range(1, 48));
   endfunction

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values frame -2.0..1.0 by -1.5..1.5 with a limit of 1000.
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(0, 1023);
      queue_pixel(1023, 0);
      queue_pixel(683, 512);
      queue_pixel(512, 512);
      queue_pixel(341, 512);
      queue_pixel(900, 200);
      drain_escapes();

      // Deepest limit: one pixel inside the set runs the full count.
      apply_setting(REAL_ORIGIN_RST, IMAG_ORIGIN_RST, REAL_STEP_RST, IMAG_STEP_RST, '1);
      queue_pixel(512, 512);
      queue_pixel(0, 0);
      drain_escapes();

      // A zero limit does no iteration at all.
      apply_setting(REAL_ORIGIN_RST, IMAG_ORIGIN_RST, REAL_STEP_RST, IMAG_STEP_RST, '0);
      queue_pixel(512, 512);
      queue_pixel(1023, 0);
      drain_escapes();

      apply_setting('0, '0, '0, '0, LIMIT_W'(1));
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      drain_escapes();

      // Largest origins and strides push c into saturation on both axes.
      apply_setting(32'sh7FFFFFFF, 32'sh80000000, '1, '1, LIMIT_W'(8));
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(1, 1);
      drain_escapes();

      apply_setting(32'sh80000000, 32'sh7FFFFFFF, '0, '1, LIMIT_W'(3));
      queue_pixel(1023, 1023);
      queue_pixel(0, 1);
      drain_escapes();

      // Writes to unused indexes must leave every register alone.
      apply_setting(REAL_ORIGIN_RST, IMAG_ORIGIN_RST, REAL_STEP_RST, IMAG_STEP_RST,
                    LIMIT_W'(2));
      @(posedge clock);
      for (int i = CSR_FIRST_UNUSED; i <= CSR_LAST_INDEX; i++)
         csr_write(CSR_IDX_W'(i), $urandom);
      csr_valid <= 1'b0;
      queue_pixel(512, 512);
      queue_pixel(0, 0);
      drain_escapes();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         calm_sides = (p % 3 == 1);
         apply_setting(pick_origin(-671088640, 805306368), pick_origin(-402653184, 805306368),
                       pick_stride(), pick_stride(), pick_limit());
         for (int k = 0; k < PIXELS_PER_PHASE; k++)
            queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
         drain_escapes();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
